// ===== rtl/apb_pkg.sv =====
// Shared types, constants and elaboration-time table functions of the additive partial bank.
`timescale 1ns / 1ps
package apb_pkg;

    typedef longint unsigned u64_t;

    localparam int GAIN_W      = 16;
    localparam int SAMPLE_W    = 16;
    localparam int ACTIVE_W    = 4;
    localparam int INC_W       = 23;
    localparam int PMAX_W      = 4;
    localparam int COEF_W      = 29;
    localparam int PROD_W      = SAMPLE_W + COEF_W;
    localparam int ACC_SHIFT   = 20;
    localparam int GAIN_SHIFT  = 23;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 23;

    localparam logic [CFG_INDEX_W-1:0] REG_INCREMENT    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PARTIALS_MAX = 1'd1;

    localparam logic [PMAX_W-1:0] PMAX_RESET = 4'd8;

    localparam u64_t PI_Q28  = 64'd843314857;
    localparam u64_t ONE_Q28 = 64'd268435456;

    // Divides one Taylor term by (2k)(2k+1).
    function automatic u64_t taylor_div(u64_t t, int k);
        case (k)
            1:       return t / 64'd6;
            2:       return t / 64'd20;
            3:       return t / 64'd42;
            4:       return t / 64'd72;
            5:       return t / 64'd110;
            6:       return t / 64'd156;
            7:       return t / 64'd210;
            8:       return t / 64'd272;
            9:       return t / 64'd342;
            10:      return t / 64'd420;
            11:      return t / 64'd506;
            12:      return t / 64'd600;
            default: return t;
        endcase
    endfunction

    // Restoring division, used only while the tables are built.
    function automatic u64_t udiv(u64_t a, u64_t b);
        u64_t rem;
        u64_t quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[62:0], a[i]};
            if (rem >= b)
            begin
                rem    = rem - b;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Sine of a Q28 angle in [0, pi], clamped to [0, 1.0].
    function automatic longint sin_q28(u64_t x);
        u64_t   x2;
        u64_t   t;
        longint sum;
        x2  = (x * x) >> 28;
        t   = x;
        sum = longint'(x);
        for (int k = 1; k <= 12; k++)
        begin
            t = taylor_div((t * x2) >> 28, k);
            if ((k & 1) != 0)
                sum = sum - longint'(t);
            else
                sum = sum + longint'(t);
        end
        if (sum < 0)
            sum = 0;
        if (sum > longint'(ONE_Q28))
            sum = longint'(ONE_Q28);
        return sum;
    endfunction

    // One entry of the first sine quadrant in Q1.15.
    function automatic u64_t quarter_val(int j, int table_bits);
        u64_t x;
        u64_t s;
        x = (PI_Q28 * u64_t'(j)) >> (table_bits - 1);
        s = u64_t'(sin_q28(x));
        return (s * 64'd32767 + (64'd1 << 27)) >> 28;
    endfunction

    // Weight of partial p when n partials are summed: sigma / (1.43 h), sign by parity.
    function automatic logic signed [COEF_W-1:0] coef_value(int p, int n);
        u64_t                     sigma;
        u64_t                     x;
        u64_t                     den;
        u64_t                     c;
        logic signed [COEF_W-1:0] mag;
        if (p == 0)
            sigma = ONE_Q28;
        else
        begin
            x     = udiv(PI_Q28 * u64_t'(p), u64_t'(n));
            sigma = udiv(u64_t'(sin_q28(x)) << 28, x);
        end
        den = 64'd143 * u64_t'(p + 1);
        c   = udiv(sigma * 64'd100 + (den >> 1), den);
        mag = COEF_W'(c);
        return ((p & 1) != 0) ? -mag : mag;
    endfunction

endpackage

// ===== rtl/apb_tick_if.sv =====
// Input channel: one sample tick carrying the envelope gain.
`timescale 1ns / 1ps
interface apb_tick_if;
    import apb_pkg::*;

    logic              valid;
    logic              ready;
    logic [GAIN_W-1:0] envelope_gain;

    modport source (output valid, output envelope_gain, input ready);
    modport sink (input valid, input envelope_gain, output ready);
endinterface

// ===== rtl/apb_result_if.sv =====
// Output channel: one audio sample and the number of partials summed.
`timescale 1ns / 1ps
interface apb_result_if;
    import apb_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic [ACTIVE_W-1:0]        partials_active;

    modport source (output valid, output sample, output partials_active, input ready);
    modport sink (input valid, input sample, input partials_active, output ready);
endinterface

// ===== rtl/additive_partial_bank.sv =====
// Top level of the additive partial bank: configuration, sequencing, cell chain and output scaling.
//
//   port     dir  handshake          content
//   tick     in   valid / ready      envelope_gain, Q1.15 gain for one sample
//   result   out  valid / ready      sample (Q1.15, saturated), partials_active
//   cfg_*    in   cfg_we             0: fundamental_increment, 1: partials_max
//
// From acceptance until the next word can be accepted, an item goes through these steps in order:
// the active count is settled, the running sum walks the chain of partials through one register
// per cell, the sum is multiplied by the gain, and the output register is loaded.
// Reset clears all phases to zero, the increment to zero and partials_max to eight.
// A result waiting in the output register stalls the final load, and with it acceptance of the next tick.
`timescale 1ns / 1ps
module additive_partial_bank #(
    parameter int PARTIALS        = 8,
    parameter int PHASE_BITS      = 24,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    apb_tick_if.sink                        tick,
    apb_result_if.source                    result,
    input  logic                            cfg_we,
    input  logic [apb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [apb_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import apb_pkg::*;

    localparam int CNT_W    = $clog2(PARTIALS + 1);
    localparam int ACC_W    = PROD_W + $clog2(PARTIALS) + 1;
    localparam int V_W      = ACC_W - ACC_SHIFT;
    localparam int PW       = V_W + GAIN_W + 1;
    localparam int SW       = PW - GAIN_SHIFT;
    localparam int INC_USED = (PHASE_BITS < INC_W) ? PHASE_BITS : INC_W;

    localparam logic signed [SW-1:0] SAT_HI = SW'(32767);
    localparam logic signed [SW-1:0] SAT_LO = SW'(-32768);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_RUN,
        ST_SCALE
    } state_t;

    logic [INC_W-1:0]  increment_reg;
    logic [PMAX_W-1:0] partials_max_reg;

    state_t                     state_reg, state_next;
    logic [GAIN_W-1:0]          gain_reg, gain_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       start_reg, start_next;
    logic signed [PW-1:0]       prod_reg, prod_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic [ACTIVE_W-1:0]        active_reg, active_next;

    logic [PHASE_BITS-1:0]      inc_eff;
    logic [PARTIALS:1]          harm_ok;
    logic [CNT_W-1:0]           count_calc;

    logic                       tok [PARTIALS+1];
    logic signed [ACC_W-1:0]    acc [PARTIALS+1];
    logic [PHASE_BITS-1:0]      step [PARTIALS+1];

    logic signed [V_W-1:0]      v_val;
    logic signed [GAIN_W:0]     gain_s;
    logic signed [SW-1:0]       scaled;
    logic signed [SAMPLE_W-1:0] sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            increment_reg    <= '0;
            partials_max_reg <= PMAX_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_INCREMENT:    increment_reg    <= cfg_data[INC_W-1:0];
                REG_PARTIALS_MAX: partials_max_reg <= cfg_data[PMAX_W-1:0];
            endcase
        end
    end

    assign inc_eff = PHASE_BITS'(increment_reg[INC_USED-1:0]);

    // Harmonic h stays below half the sample rate while inc <= (2^(PHASE_BITS-1) - 1) / h.
    assign harm_ok[1] = 1'b1;
    for (genvar h = 2; h <= PARTIALS; h++)
    begin : g_harm
        localparam logic [PHASE_BITS-1:0] THR =
            PHASE_BITS'(((64'd1 << (PHASE_BITS - 1)) - 64'd1) / h);
        assign harm_ok[h] = ({1'b0, partials_max_reg} >= (PMAX_W+1)'(h)) && (inc_eff <= THR);
    end

    always_comb
    begin
        count_calc = '0;
        for (int h = 1; h <= PARTIALS; h++)
        begin
            if (harm_ok[h])
                count_calc = CNT_W'(h);
        end
    end

    assign tok[0]  = start_reg;
    assign acc[0]  = '0;
    assign step[0] = '0;

    for (genvar p = 0; p < PARTIALS; p++)
    begin : g_cell
        apb_cell #(
            .PARTIALS        (PARTIALS),
            .PHASE_BITS      (PHASE_BITS),
            .SINE_TABLE_BITS (SINE_TABLE_BITS),
            .ACC_W           (ACC_W),
            .CNT_W           (CNT_W),
            .INDEX           (p)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .tok_in   (tok[p]),
            .acc_in   (acc[p]),
            .step_in  (step[p]),
            .inc      (inc_eff),
            .count    (count_reg),
            .tok_out  (tok[p+1]),
            .acc_out  (acc[p+1]),
            .step_out (step[p+1])
        );
    end

    // The Q43 sum drops to Q23 by a floor shift before the gain is applied.
    assign v_val  = acc[PARTIALS][ACC_W-1:ACC_SHIFT];
    assign gain_s = signed'({1'b0, gain_reg});
    assign scaled = prod_reg[PW-1:GAIN_SHIFT];

    always_comb
    begin
        if (scaled > SAT_HI)
            sat = SAMPLE_W'(SAT_HI);
        else if (scaled < SAT_LO)
            sat = SAMPLE_W'(SAT_LO);
        else
            sat = SAMPLE_W'(scaled);
    end

    always_comb
    begin
        state_next     = state_reg;
        gain_next      = gain_reg;
        count_next     = count_reg;
        start_next     = 1'b0;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg && !result.ready;
        sample_next    = sample_reg;
        active_next    = active_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (tick.valid)
                begin
                    gain_next  = tick.envelope_gain;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                count_next = count_calc;
                start_next = 1'b1;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (tok[PARTIALS])
                begin
                    prod_next  = v_val * gain_s;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    sample_next    = sat;
                    active_next    = ACTIVE_W'(count_reg);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gain_reg      <= '0;
            count_reg     <= '0;
            start_reg     <= 1'b0;
            prod_reg      <= '0;
            out_valid_reg <= 1'b0;
            sample_reg    <= '0;
            active_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            gain_reg      <= gain_next;
            count_reg     <= count_next;
            start_reg     <= start_next;
            prod_reg      <= prod_next;
            out_valid_reg <= out_valid_next;
            sample_reg    <= sample_next;
            active_reg    <= active_next;
        end
    end

    assign tick.ready             = (state_reg == ST_IDLE);
    assign result.valid           = out_valid_reg;
    assign result.sample          = sample_reg;
    assign result.partials_active = active_reg;

endmodule

// ===== rtl/apb_cell.sv =====
// One partial of the bank: phase accumulator, sine lookup and weighted add into the passing sum.
`timescale 1ns / 1ps
module apb_cell #(
    parameter int PARTIALS        = 8,
    parameter int PHASE_BITS      = 24,
    parameter int SINE_TABLE_BITS = 10,
    parameter int ACC_W           = 49,
    parameter int CNT_W           = 4,
    parameter int INDEX           = 0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    tok_in,
    input  logic signed [ACC_W-1:0] acc_in,
    input  logic [PHASE_BITS-1:0]   step_in,
    input  logic [PHASE_BITS-1:0]   inc,
    input  logic [CNT_W-1:0]        count,
    output logic                    tok_out,
    output logic signed [ACC_W-1:0] acc_out,
    output logic [PHASE_BITS-1:0]   step_out
);
    import apb_pkg::*;

    localparam int QTR   = 1 << (SINE_TABLE_BITS - 2);
    localparam int NCOEF = 1 << CNT_W;

    logic [SAMPLE_W-2:0]        qtab [QTR+1];
    logic signed [COEF_W-1:0]   coef_tab [NCOEF];

    logic [PHASE_BITS-1:0]      phase_reg;
    logic signed [SAMPLE_W-1:0] sine_reg;
    logic                       tok_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic [PHASE_BITS-1:0]      step_reg;

    logic [SINE_TABLE_BITS-1:0] idx;
    logic [1:0]                 quad;
    logic [SINE_TABLE_BITS-2:0] qidx;
    logic signed [SAMPLE_W-1:0] sine_pos;
    logic signed [SAMPLE_W-1:0] sine_next;
    logic signed [PROD_W-1:0]   prod;
    logic                       active;
    logic [PHASE_BITS-1:0]      own_step;
    logic signed [ACC_W-1:0]    acc_next;

    for (genvar j = 0; j <= QTR; j++)
    begin : g_qtab
        assign qtab[j] = (SAMPLE_W-1)'(quarter_val(j, SINE_TABLE_BITS));
    end

    // Only counts above this cell's index ever select an entry.
    for (genvar n = 0; n < NCOEF; n++)
    begin : g_coef
        if (n > INDEX && n <= PARTIALS)
        begin : g_used
            assign coef_tab[n] = coef_value(INDEX, n);
        end
        else
        begin : g_unused
            assign coef_tab[n] = '0;
        end
    end

    // Odd quadrants read the quarter table backward, the upper half is negated.
    assign idx      = phase_reg[PHASE_BITS-1 -: SINE_TABLE_BITS];
    assign quad     = idx[SINE_TABLE_BITS-1 -: 2];
    assign qidx     = quad[0] ? (SINE_TABLE_BITS-1)'(QTR) - {1'b0, idx[SINE_TABLE_BITS-3:0]}
                              : {1'b0, idx[SINE_TABLE_BITS-3:0]};
    assign sine_pos = signed'({1'b0, qtab[qidx]});
    assign sine_next = quad[1] ? -sine_pos : sine_pos;

    assign active   = count > CNT_W'(INDEX);
    assign own_step = step_in + inc;
    assign prod     = sine_reg * coef_tab[count];
    assign acc_next = acc_in + (active ? ACC_W'(prod) : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            tok_reg   <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_in;
            if (tok_in && active)
                phase_reg <= phase_reg + own_step;
        end
    end

    always_ff @(posedge clk)
    begin
        sine_reg <= sine_next;
        if (tok_in)
        begin
            acc_reg  <= acc_next;
            step_reg <= own_step;
        end
    end

    assign tok_out  = tok_reg;
    assign acc_out  = acc_reg;
    assign step_out = step_reg;

endmodule

// ===== dv/additive_partial_bank_test.sv =====
// Self-checking testbench of the additive partial bank: directed and random ticks against a predictor.
`timescale 1ns / 1ps
module additive_partial_bank_test;
    import apb_pkg::*;

    localparam int VOICES   = 8;
    localparam int PHASE_W  = 24;
    localparam int ROM_BITS = 10;
    localparam int ROM_SIZE = 1 << ROM_BITS;
    localparam int QTR      = ROM_SIZE / 4;
    localparam int RUN_LEN  = 100;
    localparam int RUNS     = 16;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [ACTIVE_W-1:0]        active;
    } voice_word_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    apb_tick_if   tick_ch();
    apb_result_if result_ch();

    additive_partial_bank dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state: lookup tables, configuration copy and per-partial phases.
    int               sine_rom [0:ROM_SIZE-1];
    longint           weight_rom [1:VOICES][0:VOICES-1];
    logic [PHASE_W-1:0] phase_acc [0:VOICES-1];
    logic [INC_W-1:0] step_reg;
    logic [PMAX_W-1:0] limit_reg;

    voice_word_t pending_words[$];
    bit          failed;
    bit          calm;
    int          stall_left;

    always #6 clk = ~clk;

    // Truncated Taylor series in Q28; every term is floored before the next one is formed.
    function automatic u64_t sine_q28(input u64_t ang);
        u64_t   sq;
        u64_t   term;
        u64_t   divisor;
        longint total;
        sq    = (ang * ang) >> 28;
        term  = ang;
        total = longint'(ang);
        for (int k = 1; k <= 12; k++)
        begin
            divisor = u64_t'((2 * k) * (2 * k + 1));
            term    = ((term * sq) >> 28) / divisor;
            if (k % 2 == 1)
                total = total - longint'(term);
            else
                total = total + longint'(term);
        end
        if (total < 0)
            total = 0;
        if (total > longint'(ONE_Q28))
            total = longint'(ONE_Q28);
        return u64_t'(total);
    endfunction

    function automatic void build_roms();
        u64_t ang;
        u64_t sig;
        u64_t den;
        u64_t mag;
        int   quad;
        int   j;
        int   v;
        for (int i = 0; i < ROM_SIZE; i++)
        begin
            quad = i / QTR;
            j    = i % QTR;
            if (quad % 2 == 1)
                j = QTR - j;
            ang = (PI_Q28 * u64_t'(j)) / u64_t'(2 * QTR);
            v   = int'((sine_q28(ang) * 64'd32767 + (64'd1 << 27)) >> 28);
            sine_rom[i] = (quad >= 2) ? -v : v;
        end
        for (int n = 1; n <= VOICES; n++)
        begin
            for (int p = 0; p < n; p++)
            begin
                if (p == 0)
                    sig = ONE_Q28;
                else
                begin
                    ang = (PI_Q28 * u64_t'(p)) / u64_t'(n);
                    sig = (sine_q28(ang) << 28) / ang;
                end
                den = 64'd143 * u64_t'(p + 1);
                mag = (sig * 64'd100 + den / 64'd2) / den;
                weight_rom[n][p] = (p % 2 == 1) ? -longint'(mag) : longint'(mag);
            end
        end
    endfunction

    // Forms the sample for one tick and steps the phases of the partials that sound.
    function automatic voice_word_t advance_voices(input logic [GAIN_W-1:0] gain);
        u64_t        step;
        int          lim;
        int          count;
        int          idx;
        longint      acc;
        longint      level;
        longint      scaled;
        voice_word_t w;
        step = u64_t'(step_reg);
        lim  = int'(limit_reg);
        if (lim < 1)
            lim = 1;
        if (lim > VOICES)
            lim = VOICES;
        count = 1;
        while (count < lim && u64_t'(count + 1) * step < (64'd1 << (PHASE_W - 1)))
            count++;
        acc = 0;
        for (int p = 0; p < count; p++)
        begin
            idx = int'(phase_acc[p][PHASE_W-1 -: ROM_BITS]);
            acc = acc + longint'(sine_rom[idx]) * weight_rom[count][p];
            phase_acc[p] = phase_acc[p] + PHASE_W'(u64_t'(p + 1) * step);
        end
        level  = acc >>> ACC_SHIFT;
        scaled = (level * longint'({48'd0, gain})) >>> GAIN_SHIFT;
        if (scaled > 32767)
            scaled = 32767;
        if (scaled < -32768)
            scaled = -32768;
        w.sample = SAMPLE_W'(scaled);
        w.active = ACTIVE_W'(count);
        return w;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return GAIN_W'($urandom_range(0, 32768));
        else if (r < 85)
            return GAIN_W'($urandom);
        else
        begin
            case ($urandom_range(0, 4))
                0:       return 16'd0;
                1:       return 16'd32768;
                2:       return 16'd32767;
                3:       return 16'hFFFF;
                default: return 16'd1;
            endcase
        end
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_increment();
        case ($urandom_range(0, 5))
            0:       return CFG_DATA_W'($urandom_range(0, 8388607));
            1:       return CFG_DATA_W'($urandom_range(0, 1048575));
            2:       return CFG_DATA_W'($urandom_range(1, 20000));
            3:       return CFG_DATA_W'($urandom_range(1048576, 4194304));
            4:       return 23'd8388607;
            default: return 23'd1048575;
        endcase
    endfunction

    // Result side: the receiver stalls at random unless the run is in a calm stretch.
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else if (calm)
            result_ch.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left      <= stall_left - 1;
            result_ch.ready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < 25)
        begin
            stall_left      <= pick_gap();
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        voice_word_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t: word with nothing expected, actual sample %0d active %0d",
                         $time, result_ch.sample, result_ch.partials_active);
                failed = 1'b1;
            end
            else
            begin
                want = pending_words.pop_front();
                if (result_ch.sample !== want.sample)
                begin
                    $display("%0t: sample mismatch, expected %0d, actual %0d",
                             $time, $signed(want.sample), result_ch.sample);
                    failed = 1'b1;
                end
                if (result_ch.partials_active !== want.active)
                begin
                    $display("%0t: partials_active mismatch, expected %0d, actual %0d",
                             $time, want.active, result_ch.partials_active);
                    failed = 1'b1;
                end
            end
        end
    end

    // Valid stays high from one word to the next when there is no gap between them.
    task automatic send_tick(input logic [GAIN_W-1:0] gain);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_ch.valid         <= 1'b1;
        tick_ch.envelope_gain <= gain;
        do
            @(posedge clk);
        while (!tick_ch.ready);
        pending_words.push_back(advance_voices(gain));
    endtask

    // Always waits at least one edge, so back-to-back register writes never overlap.
    task automatic drain_words();
        tick_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_words.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        drain_words();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_INCREMENT)
            step_reg = val[INC_W-1:0];
        else
            limit_reg = val[PMAX_W-1:0];
    endtask

    // With the increment at zero every phase stays put and all eight partials count.
    task automatic test_reset_defaults();
        send_tick(16'd32768);
        send_tick(16'hFFFF);
    endtask

    task automatic test_gain_extremes();
        write_reg(REG_INCREMENT, 23'd262144);
        send_tick(16'd0);
        send_tick(16'd1);
        send_tick(16'd32767);
        send_tick(16'd32768);
        send_tick(16'hFFFF);
        send_tick(16'hAAAA);
        send_tick(16'h5555);
    endtask

    // Zero is taken as one and anything above eight as eight; upper data bits are ignored.
    task automatic test_partials_limits();
        write_reg(REG_INCREMENT, 23'd100000);
        write_reg(REG_PARTIALS_MAX, 23'd0);
        send_tick(16'hFFFF);
        write_reg(REG_PARTIALS_MAX, 23'd1);
        send_tick(16'd32768);
        write_reg(REG_PARTIALS_MAX, 23'd9);
        send_tick(16'hFFFF);
        write_reg(REG_PARTIALS_MAX, 23'h7FFFF5);
        send_tick(16'd32768);
        write_reg(REG_PARTIALS_MAX, 23'd8);
        send_tick(16'hFFFF);
    endtask

    // Increments on both sides of the Nyquist cut for one, two, seven and eight partials.
    task automatic test_increment_extremes();
        write_reg(REG_INCREMENT, 23'd8388607);
        send_tick(16'hFFFF);
        write_reg(REG_INCREMENT, 23'd4194304);
        send_tick(16'hFFFF);
        write_reg(REG_INCREMENT, 23'd4194303);
        send_tick(16'hFFFF);
        write_reg(REG_INCREMENT, 23'd1048576);
        send_tick(16'hFFFF);
        write_reg(REG_INCREMENT, 23'd1048575);
        send_tick(16'hFFFF);
        write_reg(REG_INCREMENT, 23'd1);
        send_tick(16'd32768);
    endtask

    task automatic test_random_sweep();
        logic [CFG_DATA_W-1:0] limit_data;
        for (int run = 0; run < RUNS; run++)
        begin
            calm <= ($urandom_range(0, 4) == 0);
            limit_data = {($urandom_range(0, 1) == 1) ? 19'($urandom) : 19'd0,
                          4'($urandom_range(0, 15))};
            write_reg(REG_INCREMENT, pick_increment());
            write_reg(REG_PARTIALS_MAX, limit_data);
            for (int i = 0; i < RUN_LEN; i++)
                send_tick(pick_gain());
        end
        calm <= 1'b0;
    endtask

    initial
    begin
        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_index             <= REG_INCREMENT;
        cfg_data              <= '0;
        tick_ch.valid         <= 1'b0;
        tick_ch.envelope_gain <= '0;
        calm                  <= 1'b0;
        step_reg              = '0;
        limit_reg             = PMAX_RESET;
        for (int p = 0; p < VOICES; p++)
            phase_acc[p] = '0;
        build_roms();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_gain_extremes();
        test_partials_limits();
        test_increment_extremes();
        test_random_sweep();
        drain_words();
        repeat (VOICES + 8) @(posedge clk);
        if (!failed && pending_words.size() == 0)
            $display("PASS additive_partial_bank");
        else
            $display("FAIL additive_partial_bank");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("FAIL additive_partial_bank");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/apb_pkg.sv
rtl/apb_tick_if.sv
rtl/apb_result_if.sv
rtl/apb_cell.sv
rtl/additive_partial_bank.sv
dv/additive_partial_bank_test.sv
